// ===== sv/knnv_pkg.sv =====
package knnv_pkg;

    localparam int MAX_TRAIN = 1024;
    localparam int MAX_CLASS = 16;
    localparam int ADDR_W    = $clog2(MAX_TRAIN);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int CLS_W     = $clog2(MAX_CLASS);
    localparam int LABEL_W   = 5;
    localparam int DIST_W    = 32;
    localparam int KEY_W     = DIST_W + 1;
    localparam int ENTRY_W   = KEY_W + LABEL_W;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NEIGHBORS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_VOTES  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BREAK_TIES = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_ALL    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RNG_SEED   = 3'd4;

    typedef logic [CNT_W-1:0]   count_t;
    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [KEY_W-1:0]   key_t;
    typedef logic [ENTRY_W-1:0] entry_t;

    function automatic logic [31:0] xorshift32(input logic [31:0] x);
        logic [31:0] a;
        logic [31:0] b;
        a = x ^ (x << 13);
        b = a ^ (a >> 17);
        return b ^ (b << 5);
    endfunction

endpackage

// ===== sv/knnv_ram.sv =====
module knnv_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 38
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/knn_vote_classifier.sv =====
// k-nearest-neighbour vote for one test row.
// Input items arrive on s_axis: one training entry per item (distance,
// missing flag, class label), tlast on the final entry of the row. Entries
// load at one per cycle into a 1024-entry store; entries beyond that are
// dropped but tlast still closes the row.
// After tlast the block drops s_tready and works through the store with one
// comparator/counter: 33 radix-select passes find the k-th key, one pass
// counts entries equal to it, one pass casts votes, then a scan over the 16
// classes picks the winner. The passes run one after another through the
// single read port of the entry store.
// The result item (predicted class, winning votes, total votes) sits in an
// output register until m_tready; loading of the next row starts after it is
// taken, so a stalled receiver holds the block.
// The cfg channel is always ready; writes are meant for idle time only.
// A seed write also loads the xorshift32 generator (seed 0 loads as 1).
// Reset (aresetn low, synchronous) empties the row, restores register
// defaults and reloads the generator with 1.
module knn_vote_classifier (
    input  logic                        aclk,
    input  logic                        aresetn,
    // s_tdata: distance[31:0], missing[32], class_label[37:33], zero pad
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [39:0]                 s_tdata,
    input  logic                        s_tlast,
    // m_tdata: predicted_class[4:0], winning_votes[15:5], total_votes[26:16]
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [31:0]                 m_tdata,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [knnv_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [knnv_pkg::CFG_DAT_W-1:0] cfg_data
);
    import knnv_pkg::*;

    localparam logic [3:0] ST_LOAD = 4'd0;
    localparam logic [3:0] ST_PREP = 4'd1;
    localparam logic [3:0] ST_SEL  = 4'd2;
    localparam logic [3:0] ST_EQ   = 4'd3;
    localparam logic [3:0] ST_DRAW = 4'd4;
    localparam logic [3:0] ST_VOTE = 4'd5;
    localparam logic [3:0] ST_ARG  = 4'd6;
    localparam logic [3:0] ST_RES  = 4'd7;
    localparam logic [3:0] ST_OUT  = 4'd8;

    logic [3:0]  state_reg, state_next;
    count_t      ld_reg, ld_next;
    count_t      n_reg, n_next;
    count_t      iss_reg, iss_next;
    logic        rv_reg, rv_next;
    logic [5:0]  bit_reg, bit_next;
    key_t        prefix_reg, prefix_next;
    count_t      rank_reg, rank_next;
    count_t      cnt_reg, cnt_next;
    count_t      eq_reg, eq_next;
    count_t      pick_reg, pick_next;
    count_t      e_reg, e_next;
    count_t      counts_reg [MAX_CLASS];
    count_t      counts_next [MAX_CLASS];
    logic [CLS_W-1:0] cidx_reg, cidx_next;
    count_t      maxv_reg, maxv_next;
    count_t      total_reg, total_next;
    logic [4:0]  ties_reg, ties_next;
    logic [4:0]  best_reg, best_next;
    logic [4:0]  pred_reg, pred_next;
    logic        mval_reg, mval_next;
    logic [31:0] rng_reg, rng_next;
    count_t      nbr_reg, nbr_next;
    count_t      minv_reg, minv_next;
    logic        brk_reg, brk_next;
    logic        all_reg, all_next;

    // store ports
    logic        wr_en;
    entry_t      wr_data;
    addr_t       rd_addr;
    entry_t      rd_data;

    // working signals
    logic        in_acc;
    logic        pass_st;
    logic        issue;
    logic        pass_done;
    key_t        key;
    logic [LABEL_W-1:0] lab;
    logic        lab_ok;
    key_t        hi_mask;
    logic        cast;
    count_t      nn;
    count_t      span;
    logic [31:0] rnd;
    logic [42:0] draw_prod;
    logic [36:0] tie_prod;
    count_t      cv;

    assign in_acc   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_LOAD);
    assign m_tvalid = mval_reg;
    assign m_tdata  = {5'd0, total_reg, maxv_reg, pred_reg};
    assign cfg_ready = 1'b1;

    assign wr_en   = in_acc && (ld_reg < count_t'(MAX_TRAIN));
    assign wr_data = {s_tdata[37:33], s_tdata[32], s_tdata[31:0]};

    assign pass_st   = (state_reg == ST_SEL) || (state_reg == ST_EQ) ||
                       (state_reg == ST_VOTE);
    assign issue     = pass_st && (iss_reg < n_reg);
    assign pass_done = pass_st && (iss_reg == n_reg) && !rv_reg;
    assign rd_addr   = iss_reg[ADDR_W-1:0];

    assign key     = rd_data[KEY_W-1:0];
    assign lab     = rd_data[ENTRY_W-1:KEY_W];
    assign lab_ok  = (lab != '0) && (lab <= LABEL_W'(MAX_CLASS));
    assign hi_mask = ~((key_t'(1) << (bit_reg + 6'd1)) - key_t'(1));

    assign rnd       = xorshift32(rng_reg);
    assign span      = eq_reg - rank_reg;
    assign draw_prod = 43'(rnd) * 43'(span);
    assign tie_prod  = 37'(rnd) * 37'(ties_reg + 5'd1);
    assign cv        = counts_reg[cidx_reg];

    // a k-th key that is missing means every present entry is counted
    assign cast = prefix_reg[KEY_W-1] ? !key[KEY_W-1] :
                  ((key < prefix_reg) ||
                   ((key == prefix_reg) &&
                    (all_reg || (e_reg < rank_reg) || (e_reg == pick_reg))));

    always_comb begin
        nn = (nbr_reg == '0) ? count_t'(1) : nbr_reg;
        if (nn > n_reg) begin
            nn = n_reg;
        end
    end

    knnv_ram #(
        .DEPTH (MAX_TRAIN),
        .WIDTH (ENTRY_W)
    ) u_store (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (ld_reg[ADDR_W-1:0]),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    always_comb begin
        state_next  = state_reg;
        ld_next     = ld_reg;
        n_next      = n_reg;
        iss_next    = iss_reg;
        rv_next     = issue;
        bit_next    = bit_reg;
        prefix_next = prefix_reg;
        rank_next   = rank_reg;
        cnt_next    = cnt_reg;
        eq_next     = eq_reg;
        pick_next   = pick_reg;
        e_next      = e_reg;
        counts_next = counts_reg;
        cidx_next   = cidx_reg;
        maxv_next   = maxv_reg;
        total_next  = total_reg;
        ties_next   = ties_reg;
        best_next   = best_reg;
        pred_next   = pred_reg;
        mval_next   = mval_reg;
        rng_next    = rng_reg;
        nbr_next    = nbr_reg;
        minv_next   = minv_reg;
        brk_next    = brk_reg;
        all_next    = all_reg;

        if (issue) begin
            iss_next = iss_reg + count_t'(1);
        end

        case (state_reg)
            ST_LOAD: begin
                if (in_acc) begin
                    if (wr_en) begin
                        ld_next = ld_reg + count_t'(1);
                    end
                    if (s_tlast) begin
                        n_next     = wr_en ? ld_reg + count_t'(1) : ld_reg;
                        ld_next    = '0;
                        state_next = ST_PREP;
                    end
                end
            end
            ST_PREP: begin
                rank_next   = nn - count_t'(1);
                prefix_next = '0;
                bit_next    = 6'(KEY_W - 1);
                cnt_next    = '0;
                eq_next     = '0;
                iss_next    = '0;
                state_next  = ST_SEL;
            end
            ST_SEL: begin
                if (rv_reg && (((key ^ prefix_reg) & hi_mask) == '0) && !key[bit_reg]) begin
                    cnt_next = cnt_reg + count_t'(1);
                end
                if (pass_done) begin
                    if (rank_reg >= cnt_reg) begin
                        rank_next   = rank_reg - cnt_reg;
                        prefix_next = prefix_reg | (key_t'(1) << bit_reg);
                    end
                    cnt_next = '0;
                    iss_next = '0;
                    if (bit_reg == '0) begin
                        state_next = ST_EQ;
                    end else begin
                        bit_next = bit_reg - 6'd1;
                    end
                end
            end
            ST_EQ: begin
                if (rv_reg && (key == prefix_reg)) begin
                    eq_next = eq_reg + count_t'(1);
                end
                if (pass_done) begin
                    iss_next   = '0;
                    state_next = ST_DRAW;
                end
            end
            ST_DRAW: begin
                for (int i = 0; i < MAX_CLASS; i++) begin
                    counts_next[i] = '0;
                end
                e_next    = '0;
                pick_next = rank_reg;
                if (!all_reg && !prefix_reg[KEY_W-1] &&
                    (eq_reg > rank_reg + count_t'(1))) begin
                    rng_next  = rnd;
                    pick_next = rank_reg + draw_prod[42:32];
                end
                state_next = ST_VOTE;
            end
            ST_VOTE: begin
                if (rv_reg) begin
                    if (cast && lab_ok) begin
                        counts_next[CLS_W'(lab - 5'd1)] =
                            counts_reg[CLS_W'(lab - 5'd1)] + count_t'(1);
                    end
                    if (key == prefix_reg) begin
                        e_next = e_reg + count_t'(1);
                    end
                end
                if (pass_done) begin
                    cidx_next  = '0;
                    maxv_next  = '0;
                    total_next = '0;
                    ties_next  = '0;
                    best_next  = '0;
                    state_next = ST_ARG;
                end
            end
            ST_ARG: begin
                total_next = total_reg + cv;
                if (cv > maxv_reg) begin
                    maxv_next = cv;
                    best_next = 5'(cidx_reg) + 5'd1;
                    ties_next = 5'd1;
                end else if ((ties_reg != '0) && (cv == maxv_reg)) begin
                    rng_next = rnd;
                    if (tie_prod[36:32] == ties_reg) begin
                        best_next = 5'(cidx_reg) + 5'd1;
                    end
                    ties_next = ties_reg + 5'd1;
                end
                cidx_next = cidx_reg + CLS_W'(1);
                if (cidx_reg == CLS_W'(MAX_CLASS - 1)) begin
                    state_next = ST_RES;
                end
            end
            ST_RES: begin
                if ((minv_reg > maxv_reg) || (ties_reg == '0)) begin
                    pred_next = '0;
                end else if (!brk_reg && (ties_reg > 5'd1)) begin
                    pred_next = '0;
                end else begin
                    pred_next = best_reg;
                end
                mval_next  = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_tready) begin
                    mval_next  = 1'b0;
                    state_next = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase

        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_NEIGHBORS:  nbr_next  = cfg_data[CNT_W-1:0];
                CFG_MIN_VOTES:  minv_next = cfg_data[CNT_W-1:0];
                CFG_BREAK_TIES: brk_next  = cfg_data[0];
                CFG_USE_ALL:    all_next  = cfg_data[0];
                CFG_RNG_SEED:   rng_next  = (cfg_data == '0) ? 32'd1 : cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            ld_reg    <= '0;
            n_reg     <= '0;
            iss_reg   <= '0;
            rv_reg    <= 1'b0;
            mval_reg  <= 1'b0;
            rng_reg   <= 32'd1;
            nbr_reg   <= count_t'(1);
            minv_reg  <= '0;
            brk_reg   <= 1'b1;
            all_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            ld_reg    <= ld_next;
            n_reg     <= n_next;
            iss_reg   <= iss_next;
            rv_reg    <= rv_next;
            mval_reg  <= mval_next;
            rng_reg   <= rng_next;
            nbr_reg   <= nbr_next;
            minv_reg  <= minv_next;
            brk_reg   <= brk_next;
            all_reg   <= all_next;
        end
        bit_reg    <= bit_next;
        prefix_reg <= prefix_next;
        rank_reg   <= rank_next;
        cnt_reg    <= cnt_next;
        eq_reg     <= eq_next;
        pick_reg   <= pick_next;
        e_reg      <= e_next;
        counts_reg <= counts_next;
        cidx_reg   <= cidx_next;
        maxv_reg   <= maxv_next;
        total_reg  <= total_next;
        ties_reg   <= ties_next;
        best_reg   <= best_next;
        pred_reg   <= pred_next;
    end

    // never loading while a result waits
    a_load_out: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("load and result overlap");

    // the rank stays inside the loaded row during selection
    a_rank: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEL) |-> (rank_reg < n_reg))
        else $error("select rank out of range");

    // the winning count never exceeds the running total
    a_total: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RES) |-> (total_reg >= maxv_reg))
        else $error("winning votes above total");

    // the chosen tied entry lies within the equal group
    a_pick: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_VOTE) && !prefix_reg[KEY_W-1] |-> (pick_reg < eq_reg))
        else $error("drawn entry outside tie group");

endmodule
